// ----- src/vdw_pkg.sv -----
`default_nettype none
package vdw_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned NumWords = 9;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpVertex = 2'd1,
    OpRemap = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StRange = 2'd1,
    StLimit = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SClear,
    SHash,
    SProbe,
    SProbeWait,
    SCmp,
    SCmpWait,
    SWrite,
    SRemapWait,
    SDone
  } state_e;
endpackage
`default_nettype wire

// ----- src/vdw_hash.sv -----
`default_nettype none
// Iterative FNV-1a hash: one word per cycle while step_i is high, through a single multiplier.
module vdw_hash (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      load_i,
  input  wire logic                      step_i,
  input  wire logic [vdw_pkg::WordW-1:0] word_i,
  output logic [vdw_pkg::WordW-1:0]      hash_o
);
  import vdw_pkg::*;

  logic [WordW-1:0] hash_q, hash_d;
  logic [WordW-1:0] mix;

  assign mix = hash_q ^ word_i;

  always_comb begin
    hash_d = hash_q;
    if (load_i) begin
      hash_d = FnvBasis;
    end else if (step_i) begin
      hash_d = mix * FnvPrime;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o = hash_q;
endmodule
`default_nettype wire

// ----- src/vertex_dedup_hash_welder.sv -----
`default_nettype none
// Vertex welder: FNV-1a hash over nine words, linear-probed slot table.
// A vertex is hashed word by word, then slots are probed from the hash; a used slot that holds
// a current vertex is compared word by word, and a free slot takes a new vertex, stored word
// by word. A start request clears the slot table; a remap reads the remap table.
// One request at a time; results show for one cycle on done_o and cannot be stalled.
// After reset the block clears the slot table, with busy high.
module vertex_dedup_hash_welder #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned TABLE_SLOTS = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] norm_x_i,
  input  wire logic [31:0] norm_y_i,
  input  wire logic [31:0] norm_z_i,
  input  wire logic [31:0] tex_u_i,
  input  wire logic [31:0] tex_v_i,
  input  wire logic [31:0] rgba_i,
  input  wire logic [31:0] orig_index_i,
  output logic             done_o,
  output logic [9:0]       welded_index_o,
  output logic             is_new_o,
  output logic [1:0]       status_o,
  output logic [10:0]      welded_count_o
);
  import vdw_pkg::*;

  localparam int unsigned SlotW = $clog2(TABLE_SLOTS);
  localparam int unsigned VtxW = $clog2(MAX_VERTICES);
  localparam int unsigned CntW = VtxW + 1;
  localparam int unsigned WAddrW = $clog2(MAX_VERTICES * NumWords);
  localparam int unsigned WIdxW = 4;

  // Memories.
  logic             used_mem [TABLE_SLOTS];
  logic [VtxW-1:0]  vtx_mem [TABLE_SLOTS];
  logic [WordW-1:0] word_mem [MAX_VERTICES * NumWords];
  logic [VtxW-1:0]  remap_mem [MAX_VERTICES];

  state_e state_q, state_d;
  logic [WordW-1:0] words_q [NumWords];
  logic [1:0]       op_q;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW:0]   probes_q, probes_d;
  logic [WIdxW-1:0] widx_q, widx_d;
  logic [CntW-1:0]  seen_q, seen_d;
  logic [CntW-1:0]  dist_q, dist_d;
  logic [WAddrW-1:0] base_q, base_d;
  logic [VtxW-1:0]  idx_q, idx_d;
  logic             new_q, new_d;
  logic [1:0]       stat_q, stat_d;

  // Registered memory reads.
  logic             used_rd_q;
  logic [VtxW-1:0]  vtx_rd_q;
  logic [WordW-1:0] word_rd_q;
  logic [VtxW-1:0]  remap_rd_q;

  logic             hash_load, hash_step;
  logic [WordW-1:0] hash;
  logic [WordW-1:0] cur_word;

  // Memory control.
  logic             used_we, used_wd;
  logic [SlotW-1:0] used_wa;
  logic             vtx_we, word_we, remap_we;
  logic [WAddrW-1:0] word_ra, word_wa;

  vdw_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (hash_load),
    .step_i (hash_step),
    .word_i (cur_word),
    .hash_o (hash)
  );

  assign cur_word = words_q[widx_q];
  assign busy = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    slot_d = slot_q;
    probes_d = probes_q;
    widx_d = widx_q;
    seen_d = seen_q;
    dist_d = dist_q;
    base_d = base_q;
    idx_d = idx_q;
    new_d = 1'b0;
    stat_d = stat_q;
    hash_load = 1'b0;
    hash_step = 1'b0;
    used_we = 1'b0;
    used_wd = 1'b0;
    used_wa = slot_q;
    vtx_we = 1'b0;
    word_we = 1'b0;
    remap_we = 1'b0;
    word_wa = base_q + WAddrW'(widx_q);
    word_ra = base_q + WAddrW'(widx_q);
    done_o = 1'b0;
    case (state_q)
      SIdle: begin
        if (start) begin
          idx_d = '0;
          stat_d = StOk;
          widx_d = '0;
          hash_load = 1'b1;
          case (op_e'(op_i))
            OpStart: begin
              slot_d = '0;
              seen_d = '0;
              dist_d = '0;
              state_d = SClear;
            end
            OpVertex: begin
              if (seen_q >= CntW'(MAX_VERTICES)) begin
                stat_d = StLimit;
                state_d = SDone;
              end else begin
                state_d = SHash;
              end
            end
            OpRemap: begin
              if ({1'b0, orig_index_i} >= 33'(seen_q)) begin
                stat_d = StRange;
                state_d = SDone;
              end else begin
                state_d = SRemapWait;
              end
            end
            default: state_d = SDone;
          endcase
        end
      end
      SClear: begin
        used_we = 1'b1;
        used_wd = 1'b0;
        slot_d = slot_q + 1'b1;
        if (slot_q == SlotW'(TABLE_SLOTS - 1)) begin
          state_d = (op_q == OpStart) ? SDone : SIdle;
        end
      end
      SHash: begin
        hash_step = 1'b1;
        widx_d = widx_q + 1'b1;
        if (widx_q == WIdxW'(NumWords - 1)) begin
          state_d = SProbe;
          probes_d = '0;
        end
      end
      SProbe: begin
        if (probes_q == '0) begin
          slot_d = hash[SlotW-1:0];
        end
        state_d = SProbeWait;
      end
      SProbeWait: begin
        if (!used_rd_q) begin
          if (dist_q >= CntW'(MAX_VERTICES)) begin
            stat_d = StLimit;
            state_d = SDone;
          end else begin
            idx_d = dist_q[VtxW-1:0];
            base_d = WAddrW'(dist_q[VtxW-1:0]) * WAddrW'(NumWords);
            widx_d = '0;
            state_d = SWrite;
          end
        end else if (CntW'(vtx_rd_q) < dist_q) begin
          base_d = WAddrW'(vtx_rd_q) * WAddrW'(NumWords);
          widx_d = '0;
          state_d = SCmp;
        end else begin
          state_d = SCmpWait;
          widx_d = WIdxW'(NumWords);
        end
      end
      SCmp: begin
        state_d = SCmpWait;
      end
      SCmpWait: begin
        // One word compared per read; a mismatch moves on to the next slot.
        if (widx_q != WIdxW'(NumWords) && word_rd_q == cur_word) begin
          if (widx_q == WIdxW'(NumWords - 1)) begin
            idx_d = vtx_rd_q;
            remap_we = 1'b1;
            seen_d = seen_q + 1'b1;
            state_d = SDone;
          end else begin
            widx_d = widx_q + 1'b1;
            state_d = SCmp;
          end
        end else begin
          probes_d = probes_q + 1'b1;
          slot_d = slot_q + 1'b1;
          if (probes_q == (SlotW + 1)'(TABLE_SLOTS - 1)) begin
            stat_d = StLimit;
            state_d = SDone;
          end else begin
            state_d = SProbe;
          end
        end
      end
      SWrite: begin
        word_we = 1'b1;
        widx_d = widx_q + 1'b1;
        if (widx_q == WIdxW'(NumWords - 1)) begin
          used_we = 1'b1;
          used_wd = 1'b1;
          vtx_we = 1'b1;
          remap_we = 1'b1;
          dist_d = dist_q + 1'b1;
          seen_d = seen_q + 1'b1;
          new_d = 1'b1;
          state_d = SDone;
        end
      end
      SRemapWait: begin
        idx_d = remap_rd_q;
        state_d = SDone;
      end
      SDone: begin
        done_o = 1'b1;
        new_d = new_q;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      slot_q <= '0;
      probes_q <= '0;
      widx_q <= '0;
      seen_q <= '0;
      dist_q <= '0;
      new_q <= 1'b0;
      stat_q <= StOk;
      op_q <= OpNone;
    end else begin
      state_q <= state_d;
      slot_q <= slot_d;
      probes_q <= probes_d;
      widx_q <= widx_d;
      seen_q <= seen_d;
      dist_q <= dist_d;
      new_q <= new_d;
      stat_q <= stat_d;
      if (start && state_q == SIdle) begin
        op_q <= op_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    idx_q <= idx_d;
    if (start && state_q == SIdle) begin
      words_q[0] <= pos_x_i;
      words_q[1] <= pos_y_i;
      words_q[2] <= pos_z_i;
      words_q[3] <= norm_x_i;
      words_q[4] <= norm_y_i;
      words_q[5] <= norm_z_i;
      words_q[6] <= tex_u_i;
      words_q[7] <= tex_v_i;
      words_q[8] <= rgba_i;
    end
  end

  // Slot reads follow the next slot so the data is ready in the cycle after a probe.
  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_wa] <= used_wd;
    end
    used_rd_q <= used_mem[slot_d];
  end

  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vtx_mem[slot_q] <= idx_q;
    end
    vtx_rd_q <= vtx_mem[slot_d];
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_wa] <= cur_word;
    end
    word_rd_q <= word_mem[word_ra];
  end

  // The remap read is taken at the accepting edge, straight from the request.
  always_ff @(posedge clk_i) begin
    if (remap_we) begin
      remap_mem[seen_q[VtxW-1:0]] <= idx_d;
    end
    remap_rd_q <= remap_mem[orig_index_i[VtxW-1:0]];
  end

  assign welded_index_o = 10'(idx_q);
  assign is_new_o = new_q;
  assign status_o = stat_q;
  assign welded_count_o = 11'(dist_q);
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
module tb;
  import vdw_pkg::*;

  localparam int unsigned MaxVerts = 1024;
  localparam int unsigned Slots = 2048;
  localparam int unsigned StallLimit = 40000;

  typedef logic [31:0] vtx_t [NumWords];

  typedef struct {
    op_e         op;
    vtx_t        w;
    logic [31:0] orig;
  } req_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic        fresh;
    status_e     status;
    logic [10:0] count;
  } weld_res_t;

  typedef struct {
    req_t      rq;
    bit        typed;
    weld_res_t res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [31:0] pos_x_i, pos_y_i, pos_z_i, norm_x_i, norm_y_i, norm_z_i;
  logic [31:0] tex_u_i, tex_v_i, rgba_i, orig_index_i;
  logic        done_o;
  logic [9:0]  welded_index_o;
  logic        is_new_o;
  logic [1:0]  status_o;
  logic [10:0] welded_count_o;

  // Mirror of the welder state.
  bit          slot_used [Slots];
  logic [9:0]  slot_vtx [Slots];
  vtx_t        welded [MaxVerts];
  logic [9:0]  remap [MaxVerts];
  int unsigned seen_cnt;
  int unsigned distinct_cnt;

  weld_res_t   pending_q [$];
  vtx_t        batch_pool [$];
  int unsigned err_cnt;
  int unsigned stall_cnt;
  bit          idle_on;

  vertex_dedup_hash_welder i_dut (
    .clk_i, .rst_ni, .start, .busy, .op_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .norm_x_i, .norm_y_i, .norm_z_i,
    .tex_u_i, .tex_v_i, .rgba_i, .orig_index_i,
    .done_o, .welded_index_o, .is_new_o, .status_o, .welded_count_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic weld_res_t mk_res(logic [9:0] idx, logic fresh, status_e st,
                                       logic [10:0] cnt);
    weld_res_t r;
    r.idx = idx;
    r.fresh = fresh;
    r.status = st;
    r.count = cnt;
    return r;
  endfunction

  function automatic logic [31:0] fnv_hash(vtx_t w);
    logic [31:0] h;
    h = FnvBasis;
    for (int i = 0; i < NumWords; i++) begin
      h = (h ^ w[i]) * FnvPrime;
    end
    return h;
  endfunction

  function automatic weld_res_t weld_predict(req_t r);
    logic [31:0] h;
    int unsigned slot;
    bit          hit;
    bit          free;
    logic [9:0]  idx;
    h = 0;
    slot = 0;
    hit = 0;
    free = 0;
    idx = 0;
    case (r.op)
      OpStart: begin
        foreach (slot_used[i]) slot_used[i] = 0;
        seen_cnt = 0;
        distinct_cnt = 0;
        return mk_res(0, 0, StOk, 0);
      end
      OpVertex: begin
        if (seen_cnt >= MaxVerts) return mk_res(0, 0, StLimit, 11'(distinct_cnt));
        h = fnv_hash(r.w);
        slot = h % Slots;
        for (int p = 0; p < Slots; p++) begin
          if (!slot_used[slot]) begin
            free = 1;
            break;
          end
          if (slot_vtx[slot] < distinct_cnt && welded[slot_vtx[slot]] == r.w) begin
            idx = slot_vtx[slot];
            hit = 1;
            break;
          end
          slot = (slot + 1) % Slots;
        end
        if (hit) begin
          remap[seen_cnt] = idx;
          seen_cnt++;
          return mk_res(idx, 0, StOk, 11'(distinct_cnt));
        end
        if (!free || distinct_cnt >= MaxVerts)
          return mk_res(0, 0, StLimit, 11'(distinct_cnt));
        idx = 10'(distinct_cnt);
        welded[idx] = r.w;
        slot_used[slot] = 1;
        slot_vtx[slot] = idx;
        distinct_cnt++;
        remap[seen_cnt] = idx;
        seen_cnt++;
        return mk_res(idx, 1, StOk, 11'(distinct_cnt));
      end
      OpRemap: begin
        if (r.orig >= seen_cnt) return mk_res(0, 0, StRange, 11'(distinct_cnt));
        return mk_res(remap[r.orig], 0, StOk, 11'(distinct_cnt));
      end
      default: return mk_res(0, 0, StOk, 11'(distinct_cnt));
    endcase
  endfunction

  // Drives one request and holds it until the welder takes it.
  task automatic issue(input req_t r, input bit typed, input weld_res_t want);
    weld_res_t got;
    op_i <= r.op;
    pos_x_i <= r.w[0];
    pos_y_i <= r.w[1];
    pos_z_i <= r.w[2];
    norm_x_i <= r.w[3];
    norm_y_i <= r.w[4];
    norm_z_i <= r.w[5];
    tex_u_i <= r.w[6];
    tex_v_i <= r.w[7];
    rgba_i <= r.w[8];
    orig_index_i <= r.orig;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    got = weld_predict(r);
    pending_q.push_back(typed ? want : got);
    if (r.op == OpStart) batch_pool.delete();
    if (r.op == OpVertex) batch_pool.push_back(r.w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  function automatic vtx_t rand_vtx();
    vtx_t w;
    foreach (w[i]) w[i] = $urandom;
    return w;
  endfunction

  function automatic vtx_t fill_vtx(logic [31:0] v);
    vtx_t w;
    foreach (w[i]) w[i] = v;
    return w;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned pick;
    r.w = rand_vtx();
    r.orig = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      r.op = OpVertex;
      if (batch_pool.size() > 0 && $urandom_range(0, 1) == 0) begin
        r.w = batch_pool[$urandom_range(0, batch_pool.size() - 1)];
        // A near duplicate differs in one bit of one word.
        if ($urandom_range(0, 4) == 0)
          r.w[$urandom_range(0, NumWords - 1)] ^= 32'd1 << $urandom_range(0, 31);
      end
    end else if (pick < 94) begin
      r.op = OpRemap;
      if ($urandom_range(0, 7) != 0) r.orig = $urandom_range(0, seen_cnt + 2);
    end else if (pick < 99) begin
      r.op = OpNone;
    end else begin
      r.op = OpStart;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    weld_res_t want;
    if (done_o) begin
      if (pending_q.size() == 0) begin
        report("result with no request pending", 0, 0);
      end else begin
        want = pending_q.pop_front();
        if (welded_index_o !== want.idx)
          report("welded_index", 32'(welded_index_o), 32'(want.idx));
        if (is_new_o !== want.fresh) report("is_new", 32'(is_new_o), 32'(want.fresh));
        if (status_o !== want.status) report("status", 32'(status_o), 32'(want.status));
        if (welded_count_o !== want.count)
          report("welded_count", 32'(welded_count_o), 32'(want.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (done_o || (start && !busy)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    row_t      rows [$];
    row_t      rw;
    req_t      r;
    weld_res_t none;
    none = mk_res(0, 0, StOk, 0);
    err_cnt = 0;
    stall_cnt = 0;
    idle_on = 1;
    seen_cnt = 0;
    distinct_cnt = 0;
    foreach (slot_used[i]) slot_used[i] = 0;
    start = 1'b0;
    op_i = OpNone;
    {pos_x_i, pos_y_i, pos_z_i, norm_x_i, norm_y_i, norm_z_i} = '0;
    {tex_u_i, tex_v_i, rgba_i, orig_index_i} = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: the typed expectations follow straight from the rules.
    rw.rq.w = fill_vtx(0);
    rw.rq.orig = 0;
    rw.typed = 1;
    rw.rq.op = OpRemap; rw.res = mk_res(0, 0, StRange, 0); rows.push_back(rw);
    rw.rq.op = OpNone; rw.res = none; rows.push_back(rw);
    rw.rq.op = OpVertex; rw.res = mk_res(0, 1, StOk, 1); rows.push_back(rw);
    rw.rq.w = fill_vtx('1); rw.res = mk_res(1, 1, StOk, 2); rows.push_back(rw);
    rw.rq.w = fill_vtx(0); rw.res = mk_res(0, 0, StOk, 2); rows.push_back(rw);
    rw.rq.w = fill_vtx('1); rw.res = mk_res(1, 0, StOk, 2); rows.push_back(rw);
    rw.rq.op = OpRemap; rw.rq.orig = 1; rw.res = mk_res(1, 0, StOk, 2); rows.push_back(rw);
    rw.rq.orig = 2; rw.res = mk_res(0, 0, StOk, 2); rows.push_back(rw);
    rw.rq.orig = 4; rw.res = mk_res(0, 0, StRange, 2); rows.push_back(rw);
    rw.rq.orig = '1; rw.res = mk_res(0, 0, StRange, 2); rows.push_back(rw);
    rw.rq.op = OpNone; rw.res = mk_res(0, 0, StOk, 2); rows.push_back(rw);
    rw.typed = 0;
    for (int i = 0; i < 8; i++) begin
      rw.rq.op = OpVertex;
      rw.rq.w = rand_vtx();
      rows.push_back(rw);
      rows.push_back(rw);
    end
    rw.rq.op = OpRemap; rw.rq.orig = 20; rows.push_back(rw);
    rw.typed = 1; rw.rq.op = OpStart; rw.res = none; rows.push_back(rw);
    rw.rq.op = OpRemap; rw.rq.orig = 0; rw.res = mk_res(0, 0, StRange, 0); rows.push_back(rw);
    foreach (rows[i]) issue(rows[i].rq, rows[i].typed, rows[i].res);

    // Vertex limit: fill one batch with mostly repeated vertices.
    for (int i = 0; i < MaxVerts + 6; i++) begin
      r.op = OpVertex;
      r.orig = 0;
      if (batch_pool.size() > 0 && $urandom_range(0, 2) != 0) begin
        r.w = batch_pool[$urandom_range(0, batch_pool.size() - 1)];
      end else begin
        r.w = rand_vtx();
      end
      issue(r, 0, none);
    end
    r.op = OpRemap;
    r.orig = MaxVerts - 1;
    issue(r, 0, none);
    r.orig = MaxVerts;
    issue(r, 0, none);
    r.op = OpStart;
    issue(r, 0, none);

    for (int i = 0; i < 100; i++) begin
      if (i == 80) idle_on = 0;
      issue(rand_req(), 0, none);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/vdw_pkg.sv
src/vdw_hash.sv
src/vertex_dedup_hash_welder.sv
sim/tb.sv
